[sv/sgm_pkg.sv]
// Shared constants for the Sobel gradient magnitude block.
package sgm_pkg;

    // Payload widths
    localparam int PIX_W      = 8;
    localparam int MAG_W      = 8;
    localparam int FW_W       = 11;
    localparam int FH_W       = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    // Reset values and limits of the frame geometry
    localparam logic [FW_W-1:0] FW_RESET = 11'd320;
    localparam logic [FH_W-1:0] FH_RESET = 12'd240;
    localparam int MIN_DIM          = 3;
    localparam int MAX_LINE_DEFAULT = 1024;

    // Gradient arithmetic: |gx|, |gy| <= 1020, sum of squares < 2^21
    localparam int GRAD_W     = 10;
    localparam int SUM_W      = 12;
    localparam int RAD_W      = 21;
    localparam int ROOT_STEPS = 11;
    localparam int STEP_W     = 4;
    localparam logic [RAD_W-1:0] ROOT_BIT_INIT = RAD_W'(1) << (2 * (ROOT_STEPS - 1));

endpackage

[sv/sgm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sgm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[sv/sobel_gradient_magnitude.sv]
// Top level of the streaming 3x3 Sobel gradient magnitude block.
//
// Grey pixels enter in raster order on the s_ stream, frame after frame; the
// geometry comes from the frame_width (index 0) and frame_height (index 1)
// registers, width clamped to 3..MAX_LINE and height raised to at least 3. Both
// line stores share one RAM word per column (upper line in the high byte),
// read when a pixel is taken and written back in the following cycle. Each
// interior pixel gives min(255, isqrt(gx^2 + gy^2) / 4) on the m_ stream once
// its bottom-right neighbor has arrived; border pixels give nothing, and
// m_tlast marks the result caused by the last pixel of a frame. One pixel is
// processed at a time: a border pixel passes through accept and line store
// fetch; an interior pixel through accept, line store fetch, squaring, 11 steps
// of the bit-pair square root and hand-off to the output register, held while
// that register stays full. A finished result waits in the output register
// while the next pixel is taken. The line stores need no clearing after reset.
module sobel_gradient_magnitude
    import sgm_pkg::*;
#(
    parameter int MAX_LINE = MAX_LINE_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Pixel input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,    // [7:0] pixel
    // Magnitude output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,    // [7:0] magnitude
    output logic                  m_tlast     // frame_last
);

    localparam int CW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
    localparam int EW = (CW + 1 > FW_W) ? CW + 1 : FW_W;
    localparam int LINE_W = 2 * PIX_W;

    // Sequencer codes
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FETCH  = 3'd1;
    localparam logic [2:0] S_SQUARE = 3'd2;
    localparam logic [2:0] S_ROOT   = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [FW_W-1:0]   fw_reg;
    logic [FH_W-1:0]   fh_reg;
    logic [CW-1:0]     col_reg, col_next;
    logic [FH_W-1:0]   row_reg, row_next;
    logic [PIX_W-1:0]  win_reg [6];
    logic [PIX_W-1:0]  pix_reg;
    logic              last_reg;
    logic [GRAD_W-1:0] ax_reg, ay_reg;
    logic [RAD_W-1:0]  rem_reg, root_reg, bit_reg;
    logic [STEP_W-1:0] step_reg;
    logic              m_valid_reg;
    logic [MAG_W-1:0]  m_mag_reg;
    logic              m_last_reg;

    logic              s_accept;
    logic              out_free;
    logic [EW-1:0]     fw_ext, eff_w, col_inc;
    logic [FH_W-1:0]   eff_h;
    logic [FH_W:0]     row_inc;
    logic              col_wrap, row_wrap, interior;
    logic [LINE_W-1:0] ram_rdata;
    logic [PIX_W-1:0]  top, mid;
    logic [SUM_W-1:0]  sum_r, sum_l, sum_b, sum_t;
    logic [SUM_W-1:0]  gx, gy;
    logic [RAD_W:0]    trial;
    logic [MAG_W-1:0]  mag;

    assign s_accept  = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_mag_reg;
    assign m_tlast  = m_last_reg;

    // Effective frame geometry
    assign fw_ext = EW'(fw_reg);
    always_comb begin
        priority if (fw_ext < EW'(MIN_DIM)) begin
            eff_w = EW'(MIN_DIM);
        end else if (fw_ext > EW'(MAX_LINE)) begin
            eff_w = EW'(MAX_LINE);
        end else begin
            eff_w = fw_ext;
        end
    end
    assign eff_h = (fh_reg < FH_W'(MIN_DIM)) ? FH_W'(MIN_DIM) : fh_reg;

    // Position of the pixel in flight
    assign col_inc  = EW'(col_reg) + EW'(1);
    assign row_inc  = {1'b0, row_reg} + (FH_W + 1)'(1);
    assign col_wrap = (col_inc >= eff_w);
    assign row_wrap = (row_inc >= {1'b0, eff_h});
    assign interior = (row_reg >= FH_W'(2)) && (EW'(col_reg) >= EW'(2));

    always_comb begin
        col_next = col_wrap ? '0 : col_inc[CW-1:0];
        row_next = row_reg;
        if (col_wrap) begin
            row_next = row_wrap ? '0 : row_inc[FH_W-1:0];
        end
    end

    // Line stores: high byte holds the line two above, low byte the line above
    sgm_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_LINE)
    ) u_line_ram (
        .clk     (aclk),
        .wr_en   (state_reg == S_FETCH),
        .wr_addr (col_reg),
        .wr_data ({mid, pix_reg}),
        .rd_en   (s_accept),
        .rd_addr (col_reg),
        .rd_data (ram_rdata)
    );

    assign top = ram_rdata[LINE_W-1:PIX_W];
    assign mid = ram_rdata[PIX_W-1:0];

    // Sobel sums: right/left columns for gx, bottom/top rows for gy
    assign sum_r = SUM_W'(top) + SUM_W'({mid, 1'b0}) + SUM_W'(pix_reg);
    assign sum_l = SUM_W'(win_reg[3]) + SUM_W'({win_reg[4], 1'b0}) + SUM_W'(win_reg[5]);
    assign sum_b = SUM_W'(win_reg[5]) + SUM_W'({win_reg[2], 1'b0}) + SUM_W'(pix_reg);
    assign sum_t = SUM_W'(win_reg[3]) + SUM_W'({win_reg[0], 1'b0}) + SUM_W'(top);
    assign gx    = sum_r - sum_l;
    assign gy    = sum_b - sum_t;

    // One bit-pair step of the integer square root
    assign trial = {1'b0, root_reg} + {1'b0, bit_reg};

    // Scale and saturate the root
    assign mag = (root_reg[RAD_W-1:MAG_W+2] != '0) ? '1 : root_reg[MAG_W+1:2];

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (s_accept) state_next = S_FETCH;
            S_FETCH:  state_next = interior ? S_SQUARE : S_IDLE;
            S_SQUARE: state_next = S_ROOT;
            S_ROOT:   if (step_reg == '0) state_next = S_DONE;
            S_DONE:   if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fw_reg      <= FW_RESET;
            fh_reg      <= FH_RESET;
            col_reg     <= '0;
            row_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH:  fw_reg <= cfg_data[FW_W-1:0];
                    REG_FRAME_HEIGHT: fh_reg <= cfg_data[FH_W-1:0];
                    default: ;
                endcase
            end
            // Advance the window and the position once the column is fetched
            if (state_reg == S_FETCH) begin
                col_reg    <= col_next;
                row_reg    <= row_next;
                win_reg[3] <= win_reg[0];
                win_reg[4] <= win_reg[1];
                win_reg[5] <= win_reg[2];
                win_reg[0] <= top;
                win_reg[1] <= mid;
                win_reg[2] <= pix_reg;
            end
            // Output register: load when free, drop when taken
            if (state_reg == S_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            pix_reg <= s_tdata[PIX_W-1:0];
        end
        if (state_reg == S_FETCH) begin
            last_reg <= col_wrap && row_wrap;
            ax_reg   <= gx[SUM_W-1] ? GRAD_W'(-gx) : gx[GRAD_W-1:0];
            ay_reg   <= gy[SUM_W-1] ? GRAD_W'(-gy) : gy[GRAD_W-1:0];
        end
        if (state_reg == S_SQUARE) begin
            rem_reg  <= RAD_W'(ax_reg) * RAD_W'(ax_reg) + RAD_W'(ay_reg) * RAD_W'(ay_reg);
            root_reg <= '0;
            bit_reg  <= ROOT_BIT_INIT;
            step_reg <= STEP_W'(ROOT_STEPS - 1);
        end
        if (state_reg == S_ROOT) begin
            if ({1'b0, rem_reg} >= trial) begin
                rem_reg  <= rem_reg - trial[RAD_W-1:0];
                root_reg <= (root_reg >> 1) + bit_reg;
            end else begin
                root_reg <= root_reg >> 1;
            end
            bit_reg  <= bit_reg >> 2;
            step_reg <= step_reg - STEP_W'(1);
        end
        if (state_reg == S_DONE && out_free) begin
            m_mag_reg  <= mag;
            m_last_reg <= last_reg;
        end
    end

endmodule

[sv/sgm_checker.sv]
// Port-level checks for the Sobel gradient magnitude block, bound to the top level.
module sgm_checker
    import sgm_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       cfg_valid,
    input logic       cfg_ready,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // Hold a stalled result valid
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // Hold a stalled result payload
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result payload changed while stalled");

    // One pixel at a time: no transaction in the cycle after one
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("pixel taken while previous one in flight");

    // A result never appears right after the pixel that caused it
    a_out_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
        else $error("result appeared too early");

    // Configuration is always taken
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind sobel_gradient_magnitude sgm_checker u_sgm_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
);

[verif/tb_sobel_gradient_magnitude.sv]
// Self-checking stream testbench for the Sobel gradient magnitude block.
module tb_sobel_gradient_magnitude
    import sgm_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 2000000;

    typedef struct {
        logic [MAG_W-1:0] magnitude;
        logic             frame_last;
    } sobel_result_t;

    // Line stores, 3x3 window and raster counters mirrored in software
    class sobel_scoreboard;
        logic [FW_W-1:0] width_reg;
        logic [FH_W-1:0] height_reg;
        logic [7:0]      line_two_up [MAX_LINE_DEFAULT];
        logic [7:0]      line_one_up [MAX_LINE_DEFAULT];
        int              prev_top, prev_mid, prev_bot;   // column c-1
        int              old_top, old_mid, old_bot;      // column c-2
        int unsigned     col, row;
        sobel_result_t   magnitudes_due[$];
        int              mismatches;

        function new();
            width_reg  = FW_RESET;
            height_reg = FH_RESET;
            foreach (line_two_up[i]) begin
                line_two_up[i] = '0;
                line_one_up[i] = '0;
            end
            prev_top = 0; prev_mid = 0; prev_bot = 0;
            old_top  = 0; old_mid  = 0; old_bot  = 0;
            col = 0;
            row = 0;
            mismatches = 0;
        endfunction

        function int unsigned eff_width();
            int unsigned w;
            w = width_reg;
            if (w < MIN_DIM) w = MIN_DIM;
            if (w > MAX_LINE_DEFAULT) w = MAX_LINE_DEFAULT;
            return w;
        endfunction

        function int unsigned eff_height();
            int unsigned h;
            h = height_reg;
            if (h < MIN_DIM) h = MIN_DIM;
            return h;
        endfunction

        function void set_geometry_reg(logic [CFG_IDX_W-1:0] idx,
                                       logic [CFG_DATA_W-1:0] value);
            if (idx == REG_FRAME_WIDTH) begin
                width_reg = value[FW_W-1:0];
            end else begin
                height_reg = value[FH_W-1:0];
            end
        endfunction

        // Floor of the square root, one result bit at a time
        function int unsigned root_floor(int unsigned v);
            int unsigned r;
            int unsigned trial;
            r = 0;
            for (int b = 11; b >= 0; b--) begin
                trial = r + (1 << b);
                if (trial * trial <= v) r = trial;
            end
            return r;
        endfunction

        function void take_pixel(logic [7:0] pix);
            int unsigned ew, eh, slot, mag;
            int          above2, above1, here, gx, gy;
            sobel_result_t res;
            ew     = eff_width();
            eh     = eff_height();
            slot   = (col < MAX_LINE_DEFAULT) ? col : MAX_LINE_DEFAULT - 1;
            above2 = int'(line_two_up[slot]);
            above1 = int'(line_one_up[slot]);
            here   = int'(pix);
            // shift the column of the line stores up by one line
            line_two_up[slot] = line_one_up[slot];
            line_one_up[slot] = pix;
            if (row >= 2 && col >= 2) begin
                gx  = (above2 + 2 * above1 + here) - (old_top + 2 * old_mid + old_bot);
                gy  = (old_bot + 2 * prev_bot + here) - (old_top + 2 * prev_top + above2);
                mag = root_floor(gx * gx + gy * gy) >> 2;
                res.magnitude  = (mag > 255) ? 8'd255 : mag[7:0];
                res.frame_last = (row + 1 >= eh) && (col + 1 >= ew);
                magnitudes_due = {magnitudes_due, res};
            end
            // slide the window one column right
            old_top  = prev_top; old_mid = prev_mid; old_bot = prev_bot;
            prev_top = above2;   prev_mid = above1;  prev_bot = here;
            // advance the raster position
            if (col + 1 >= ew) begin
                col = 0;
                row = (row + 1 >= eh) ? 0 : row + 1;
            end else begin
                col = col + 1;
            end
        endfunction

        function void check_magnitude(logic [MAG_W-1:0] mag, logic last);
            sobel_result_t due;
            if (magnitudes_due.size() == 0) begin
                $error("magnitude %0d (frame_last %0b) arrived with none pending", mag, last);
                mismatches++;
            end else begin
                due = magnitudes_due.pop_front();
                if (mag !== due.magnitude) begin
                    $error("magnitude: expected %0d, got %0d", due.magnitude, mag);
                    mismatches++;
                end
                if (last !== due.frame_last) begin
                    $error("frame_last: expected %0b, got %0b", due.frame_last, last);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;    // [7:0] pixel
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;           // [7:0] magnitude
    logic                  m_tlast;           // frame_last

    sobel_scoreboard sb;
    int          items_sent   = 0;
    int          burst_left   = 0;
    int          results_seen = 0;
    int          stall_mode   = 0;
    int          stall_phase  = 0;
    int          hold_left    = 0;
    bit          hold_done    = 1'b0;
    int unsigned cycles       = 0;
    int          pix_mode, ramp_x, ramp_y, flat_level;

    sobel_gradient_magnitude u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #1 aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Check each result transaction; stall on a pattern, with one long hold-off
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_magnitude(m_tdata, m_tlast);
            results_seen++;
        end
        if (stall_phase == 0) stall_mode = $urandom_range(0, 2);
        stall_phase = (stall_phase + 1) % 64;
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!hold_done && results_seen >= 80 && s_tvalid) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_geometry_reg(idx, value);
    endtask

    task automatic write_geometry(input logic [CFG_DATA_W-1:0] width_data,
                                  input logic [CFG_DATA_W-1:0] height_data);
        write_reg(REG_FRAME_WIDTH, width_data);
        write_reg(REG_FRAME_HEIGHT, height_data);
        cfg_valid <= 1'b0;
    endtask

    // Offer one pixel, opening a new burst after a random gap when due
    task automatic send_pixel(input logic [7:0] pix);
        int gap;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.take_pixel(pix);
        items_sent++;
        burst_left--;
    endtask

    // Drop valid, wait for every pending result, then let the block go idle
    task automatic settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.magnitudes_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic void new_pattern();
        pix_mode   = $urandom_range(0, 4);
        ramp_x     = $urandom_range(0, 64);
        ramp_y     = $urandom_range(0, 64);
        flat_level = $urandom_range(0, 255);
    endfunction

    function automatic logic [7:0] pick_pixel();
        int unsigned v;
        case (pix_mode)
            1: v = $urandom_range(0, 1) ? 255 : 0;
            2: v = sb.col * ramp_x + sb.row * ramp_y + flat_level;
            3: v = flat_level + $urandom_range(0, 3);
            default: v = $urandom_range(0, 255);
        endcase
        return v[7:0];
    endfunction

    // Send pixels until the raster position is back at the frame start
    task automatic send_frame();
        new_pattern();
        do begin
            send_pixel(pick_pixel());
        end while (sb.col != 0 || sb.row != 0);
    endtask

    initial begin
        logic [7:0]            step_edge [9];
        int unsigned           ew, eh, w, h, sel, phase_no;
        logic [CFG_DATA_W-1:0] wd;

        step_edge = '{8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255};
        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Width and height below range both give a 3x3 frame
        write_geometry(12'h000, 12'h001);
        // vertical step edge drives the magnitude to its maximum
        foreach (step_edge[i]) send_pixel(step_edge[i]);
        // checkerboard
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                send_pixel(((r + c) % 2) ? 8'hFF : 8'h00);
            end
        end
        settle();
        // ignored width bit set; flat frame with one dark corner
        write_geometry(12'h802, 12'h002);
        for (int i = 0; i < 9; i++) send_pixel((i == 0) ? 8'h00 : 8'hFF);

        // Random phases, each starting at a frame boundary
        phase_no = 0;
        while (items_sent < RANDOM_ITEMS) begin
            settle();
            if (phase_no == 1) begin
                // widest line: width above range clamps to the line store depth
                write_geometry(12'hFFF, 12'($urandom_range(0, 2)));
                new_pattern();
                repeat (MAX_LINE_DEFAULT + $urandom_range(1, 4)) send_pixel(pick_pixel());
                settle();
                // narrow the line so the frame closes after a short third line
                write_geometry(12'd3, 12'd3);
                send_frame();
            end else if (phase_no == 3) begin
                // tallest frame, cut short by lowering the height mid-frame
                write_geometry({1'($urandom_range(0, 1)), 11'd3}, 12'hFFF);
                new_pattern();
                repeat (60 + $urandom_range(0, 2)) send_pixel(pick_pixel());
                settle();
                write_geometry(12'd3, 12'd5);
                send_frame();
            end else begin
                sel = $urandom_range(0, 9);
                w = (sel == 0) ? $urandom_range(0, 2)
                  : (sel == 1) ? $urandom_range(17, 48) : $urandom_range(3, 16);
                h = (sel == 2) ? $urandom_range(0, 2) : $urandom_range(3, 9);
                wd = {1'($urandom_range(0, 1)), 11'(w)};
                write_geometry(wd, 12'(h));
                repeat ($urandom_range(1, 3)) begin
                    if ($urandom_range(0, 5) == 0) begin
                        // narrow the line and change the height mid-frame
                        ew = sb.eff_width();
                        eh = sb.eff_height();
                        new_pattern();
                        repeat ($urandom_range(1, ew * eh - 1)) send_pixel(pick_pixel());
                        settle();
                        wd = {1'($urandom_range(0, 1)), 11'($urandom_range(0, ew))};
                        write_geometry(wd, 12'($urandom_range(0, 9)));
                    end
                    send_frame();
                end
            end
            phase_no++;
        end

        settle();
        if (sb.mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
